### rtl/bgct_pkg.sv
// package for the box gated centroid tracker
// holds shared widths, config indexes and the divider command struct
package bgct_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 20;
  localparam int unsigned SumW   = 51;
  localparam int unsigned DivW   = 128;

  // kept points per frame; the sum width above holds this many 32-bit points
  localparam int unsigned MaxPoints = 524288;

  localparam logic [2:0] RegFrameXLo = 3'd0;
  localparam logic [2:0] RegFrameXHi = 3'd1;
  localparam logic [2:0] RegFrameYLo = 3'd2;
  localparam logic [2:0] RegFrameYHi = 3'd3;
  localparam logic [2:0] RegFrameZLo = 3'd4;
  localparam logic [2:0] RegFrameZHi = 3'd5;
  localparam logic [2:0] RegHalfW    = 3'd6;
  localparam logic [2:0] RegMinPts   = 3'd7;

  localparam logic [41:0] DispLimit = 42'h200_0000_0000;

  // request to the shared divider
  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  num;
    logic [TimeW-1:0] den;
  } div_req_t;

  // answer from the shared divider
  typedef struct packed {
    logic        done;
    logic [42:0] quot;
    logic        sat;
    logic        round_up;
  } div_rsp_t;

endpackage

### rtl/bgct_div.sv
// shared restoring divider, one quotient bit per cycle
// uses bgct_pkg for the request and response structs
module bgct_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bgct_pkg::div_req_t req_i,
  output bgct_pkg::div_rsp_t rsp_o
);

  logic [bgct_pkg::DivW-1:0]    num_q, num_d;
  logic [bgct_pkg::TimeW:0]     rem_q, rem_d;
  logic [bgct_pkg::TimeW-1:0]   den_q, den_d;
  logic [42:0]                  quot_q, quot_d;
  logic                         sat_q, sat_d;
  logic [7:0]                   cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [bgct_pkg::TimeW:0]     shifted;
  logic [bgct_pkg::TimeW:0]     diffv;
  logic                         ge;
  logic [42:0]                  qn;

  // one restoring step
  always_comb begin
    shifted = {rem_q[bgct_pkg::TimeW-1:0], num_q[bgct_pkg::DivW-1]};
    ge      = shifted >= {1'b0, den_q};
    diffv   = shifted - {1'b0, den_q};
    qn      = sat_q ? quot_q : {quot_q[41:0], ge};
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    sat_d   = sat_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quot_d = '0;
      sat_d  = 1'b0;
      cnt_d  = 8'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d  = {num_q[bgct_pkg::DivW-2:0], 1'b0};
      rem_d  = ge ? diffv : shifted;
      quot_d = qn;
      if (qn > {1'b0, bgct_pkg::DispLimit}) sat_d = 1'b1;
      cnt_d  = cnt_q + 8'd1;
      if (cnt_q == 8'(bgct_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    sat_q  <= sat_d;
  end

  // remainder doubled against divisor gives round to nearest
  assign rsp_o.done     = done_q;
  assign rsp_o.quot     = quot_q;
  assign rsp_o.sat      = sat_q;
  assign rsp_o.round_up = ({rem_q, 1'b0} >= {2'b0, den_q});

  // done follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("divider done without work");
  // no new start while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !req_i.start)
    else $error("divider restarted while busy");
  // saturation is sticky within a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && sat_q && !req_i.start) |=> sat_q)
    else $error("divider saturation dropped");

endmodule

### rtl/box_gated_centroid_tracker.sv
// box gated centroid tracker top level: point gating, sums and sequencer
// depends on bgct_pkg and bgct_div
//
// points enter on the point channel (in_valid_i/in_ready_o); one result per
// frame leaves on the result channel (out_valid_o/out_ready_i). config
// writes use cfg_valid_i, cfg_ready_o, cfg_index_i and cfg_data_i, register
// i at index i.
// a point that opens a frame in predicting mode fixes the search box first:
// per axis a split multiply over two 24-bit halves and a 128-step division
// on the shared divider; other points go straight to the gate step.
// a frame end point runs three 128-step centroid divisions on the same
// divider, one per axis, before the result is offered.
// the shared divider is a restoring divider that produces one bit per cycle.
// the block is not ready while a point is at work.
// reset brings locate mode, zero history and the default config.
// a stalled receiver holds the result in the output register; points of the
// next frame are still taken, and its centroid divisions wait until the
// held result is taken.
module box_gated_centroid_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic               point_valid_i,
  input  logic               frame_end_i,
  input  logic [47:0]        frame_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] centroid_x_o,
  output logic signed [31:0] centroid_y_o,
  output logic signed [31:0] centroid_z_o,
  output logic               not_found_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned CntW = $clog2(bgct_pkg::MaxPoints + 1);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StMul   = 7'b0000010,
    StPred  = 7'b0000100,
    StPWait = 7'b0001000,
    StGate  = 7'b0010000,
    StMean  = 7'b0100000,
    StMWait = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic signed [31:0] frame_q [6];
  logic [30:0]        half_q;
  logic [19:0]        minp_q;

  // tracker state
  logic               locating_q;
  logic [1:0]         phase_q;
  logic signed [31:0] last_q [3];
  logic signed [31:0] prev_q [3];
  logic [47:0]        lt_q, pt_q;
  logic signed [50:0] sum_q [3];
  logic [CntW-1:0]    cnt_q;
  logic signed [31:0] box_q [6];
  logic               in_frame_q;
  logic [1:0]         axis_q;

  // latched point
  logic signed [31:0] px_q [3];
  logic               pv_q, fe_q;
  logic [47:0]        ft_q;

  logic signed [31:0] res_q [3];
  logic               nf_q;
  logic               out_valid_q;
  logic [56:0]        prod_lo_q;

  bgct_pkg::div_req_t dreq;
  bgct_pkg::div_rsp_t drsp;

  bgct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  logic [47:0]        dprev, dnow;
  logic signed [32:0] diff;
  logic [32:0]        dmag;
  logic [23:0]        mul_b;
  logic [56:0]        mul_p;
  logic               dneg;
  logic signed [50:0] sum_sel;
  logic [50:0]        smag;
  logic [42:0]        qr;
  logic signed [44:0] disp;
  logic signed [45:0] centre_w;
  logic signed [31:0] centre;
  logic signed [33:0] lo_w, hi_w;
  logic signed [31:0] mean_v;
  logic               in_box;
  logic [2:0]         ax_ix;
  logic               pred_go;
  logic               out_free;
  logic               frame_miss;

  function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
    if (v > 46'sd2147483647) return 32'sh7fffffff;
    if (v < -46'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // shared operand selection
  always_comb begin
    dprev   = lt_q - pt_q;
    dnow    = ft_q - lt_q;
    diff    = 33'(last_q[axis_q]) - 33'(prev_q[axis_q]);
    dneg    = diff[32];
    dmag    = dneg ? -diff : diff;
    // product split in two 24-bit halves of the time step
    mul_b   = (state_q == StMul) ? dnow[23:0] : dnow[47:24];
    mul_p   = dmag * mul_b;
    sum_sel = sum_q[axis_q];
    smag    = sum_sel[50] ? -sum_sel : sum_sel;
    qr      = (drsp.sat || (drsp.quot + 43'(drsp.round_up) > 43'(bgct_pkg::DispLimit)))
              ? 43'(bgct_pkg::DispLimit) : drsp.quot + 43'(drsp.round_up);
    disp    = dneg ? -45'(qr) : 45'(qr);
    centre_w = 46'(last_q[axis_q]) + 46'(disp);
    centre  = (state_q == StPWait) ? sat32(centre_w) : last_q[axis_q];
    lo_w    = 34'(centre) - 34'({1'b0, half_q});
    hi_w    = 34'(centre) + 34'({1'b0, half_q});
    mean_v  = sat32(46'(sum_sel[50] ? -$signed({1'b0, drsp.quot}) :
                                          $signed({1'b0, drsp.quot})));
    in_box  = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (px_q[a] < box_q[2*a] || px_q[a] > box_q[2*a+1]) in_box = 1'b0;
    end
    ax_ix = {axis_q, 1'b0};
    pred_go = !in_frame_q && !locating_q && (phase_q >= 2'd2) && (dprev != 48'd0);
    out_free = !out_valid_q || out_ready_i;
    frame_miss = locating_q ? !(32'(cnt_q) > 32'(minp_q)) : (32'(cnt_q) < 32'(minp_q));
  end

  // divider request
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = dprev;
    if (state_q == StPred) begin
      dreq.start = 1'b1;
      dreq.num   = 128'(prod_lo_q) + (128'(mul_p) << 24);
      dreq.den   = dprev;
    end else if (state_q == StMean && out_free) begin
      dreq.start = 1'b1;
      dreq.num   = 128'(smag) + 128'(cnt_q >> 1);
      dreq.den   = 48'(cnt_q);
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign centroid_x_o = nf_q ? 32'sd0 : res_q[0];
  assign centroid_y_o = nf_q ? 32'sd0 : res_q[1];
  assign centroid_z_o = nf_q ? 32'sd0 : res_q[2];
  assign not_found_o  = nf_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = pred_go ? StMul : StGate;
      StMul:   state_d = StPred;
      StPred:  state_d = StPWait;
      StPWait: if (drsp.done) state_d = (axis_q == 2'd2) ? StGate : StMul;
      StGate:  state_d = fe_q ? StMean : StIdle;
      StMean:  if (out_free) state_d = StMWait;
      StMWait: if (drsp.done) state_d = (axis_q == 2'd2) ? StIdle : StMean;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      for (int a = 0; a < 6; a++)
        frame_q[a] <= (a % 2 == 1) ? 32'sh7fffffff : 32'sh80000000;
      half_q     <= 31'd6554;
      minp_q     <= 20'd5;
      locating_q <= 1'b1;
      phase_q    <= 2'd0;
      for (int a = 0; a < 3; a++) begin
        last_q[a] <= '0;
        prev_q[a] <= '0;
        sum_q[a]  <= '0;
        res_q[a]  <= '0;
      end
      lt_q       <= '0;
      pt_q       <= '0;
      cnt_q      <= '0;
      for (int a = 0; a < 6; a++) box_q[a] <= '0;
      in_frame_q <= 1'b0;
      axis_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // config writes
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bgct_pkg::RegHalfW:  half_q <= cfg_data_i[30:0];
          bgct_pkg::RegMinPts: minp_q <= cfg_data_i[19:0];
          default:             frame_q[cfg_index_i] <= cfg_data_i;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && !in_frame_q) begin
            for (int a = 0; a < 3; a++) sum_q[a] <= '0;
            cnt_q  <= '0;
            axis_q <= '0;
            if (locating_q) begin
              for (int a = 0; a < 6; a++) box_q[a] <= frame_q[a];
            end else begin
              if (phase_q == 2'd1) phase_q <= 2'd2;
              if (!pred_go) begin
                for (int a = 0; a < 3; a++) begin
                  box_q[2*a]   <= sat32(46'(last_q[a]) - 46'({1'b0, half_q}));
                  box_q[2*a+1] <= sat32(46'(last_q[a]) + 46'({1'b0, half_q}));
                end
              end
            end
          end
        end
        StPWait: begin
          if (drsp.done) begin
            box_q[ax_ix]        <= sat32(46'(lo_w));
            box_q[ax_ix + 3'd1] <= sat32(46'(hi_w));
            axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
          end
        end
        StGate: begin
          if (pv_q && in_box && cnt_q < CntW'(bgct_pkg::MaxPoints)) begin
            for (int a = 0; a < 3; a++) sum_q[a] <= sum_q[a] + 51'(px_q[a]);
            cnt_q <= cnt_q + 1'b1;
          end
          in_frame_q <= !fe_q;
          if (fe_q) axis_q <= '0;
        end
        StMWait: begin
          if (drsp.done) begin
            res_q[axis_q] <= (cnt_q == '0) ? 32'sd0 : mean_v;
            axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
          end
        end
        default: ;
      endcase
      // result register handshake
      if (state_q == StMWait && drsp.done && axis_q == 2'd2) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      // frame decision once centroids are known
      if (state_q == StMWait && drsp.done && axis_q == 2'd2) begin
        if (locating_q) begin
          if (32'(cnt_q) > 32'(minp_q)) begin
            locating_q <= 1'b0;
            phase_q    <= 2'd1;
          end else phase_q <= 2'd0;
        end else if (32'(cnt_q) < 32'(minp_q)) begin
          locating_q <= 1'b1;
          phase_q    <= 2'd0;
        end
        if (locating_q || !(32'(cnt_q) < 32'(minp_q))) begin
          pt_q <= lt_q;
          lt_q <= ft_q;
          for (int a = 0; a < 2; a++) begin
            prev_q[a] <= last_q[a];
            last_q[a] <= (cnt_q == '0) ? 32'sd0 : res_q[a];
          end
          prev_q[2] <= last_q[2];
          last_q[2] <= (cnt_q == '0) ? 32'sd0 : mean_v;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      px_q[0] <= point_x_i;
      px_q[1] <= point_y_i;
      px_q[2] <= point_z_i;
      pv_q    <= point_valid_i;
      fe_q    <= frame_end_i;
      ft_q    <= frame_time_i;
    end
    if (state_q == StMul) prod_lo_q <= mul_p;
    if (state_q == StMWait && drsp.done && axis_q == 2'd2) begin
      nf_q <= frame_miss;
    end
  end

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(centroid_x_o) && $stable(centroid_y_o) &&
                                       $stable(centroid_z_o) && $stable(not_found_o)))
    else $error("result changed while pending");
  // a held result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");
  // kept count never passes the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(bgct_pkg::MaxPoints))
    else $error("count overflow");
  // tracking phase is zero in locate mode after a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (locating_q && state_q == StIdle && !in_frame_q) |-> phase_q == 2'd0)
    else $error("phase set in locate mode");

endmodule

### dv/box_gated_centroid_tracker_checker.sv
// checker for the box gated centroid tracker: watches the point, result and config
// channels, predicts every frame result and compares it; depends on bgct_pkg
module box_gated_centroid_tracker_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic               point_valid_i,
  input  logic               frame_end_i,
  input  logic [47:0]        frame_time_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] centroid_x_i,
  input  logic signed [31:0] centroid_y_i,
  input  logic signed [31:0] centroid_z_i,
  input  logic               not_found_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 found_o
);

  localparam int unsigned MaxKept = bgct_pkg::MaxPoints;
  localparam longint DispCap = 64'h200_0000_0000;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic               lost;
  } frame_result_t;

  frame_result_t result_q[$];

  // configuration copy
  logic signed [31:0] frame_bound[6];
  logic [30:0]        half_width;
  logic [19:0]        min_pts;

  // tracker state copy
  bit                 locating;
  int                 track_phase;
  logic signed [31:0] last_pos[3];
  logic signed [31:0] prev_pos[3];
  logic [47:0]        last_time;
  logic [47:0]        prev_time;
  longint             sums[3];
  int unsigned        kept;
  logic signed [31:0] gate[6];
  bit                 in_frame;

  assign pending_o = result_q.size();

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // velocity displacement: round(diff * dnow / dprev), magnitude capped
  function automatic longint velocity_step(longint diff, logic [47:0] dnow, logic [47:0] dprev);
    logic [127:0] mag;
    logic [127:0] prod;
    logic [127:0] q;
    logic [127:0] r;
    mag = (diff < 0) ? 128'(-diff) : 128'(diff);
    prod = mag * 128'(dnow);
    q = prod / 128'(dprev);
    r = prod % 128'(dprev);
    if (r >= 128'(dprev) - r) q = q + 1;
    if (q > 128'(DispCap)) q = 128'(DispCap);
    return (diff < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic signed [31:0] centroid_of(longint sum, int unsigned n);
    longint mag;
    longint q;
    if (n == 0) return '0;
    mag = (sum < 0) ? -sum : sum;
    q = (mag + longint'(n / 2)) / longint'(n);
    return clip32((sum < 0) ? -q : q);
  endfunction

  function automatic void open_frame(logic [47:0] now);
    longint centre;
    longint diff;
    logic [47:0] dprev;
    logic [47:0] dnow;
    if (locating) begin
      for (int a = 0; a < 6; a++) gate[a] = frame_bound[a];
      return;
    end
    for (int a = 0; a < 3; a++) begin
      centre = last_pos[a];
      if (track_phase >= 2) begin
        dprev = last_time - prev_time;
        dnow = now - last_time;
        if (dprev != 0) begin
          diff = longint'(last_pos[a]) - longint'(prev_pos[a]);
          centre = clip32(centre + velocity_step(diff, dnow, dprev));
        end
      end
      gate[2*a]   = clip32(centre - longint'(half_width));
      gate[2*a+1] = clip32(centre + longint'(half_width));
    end
    if (track_phase == 1) track_phase = 2;
  endfunction

  function automatic void take_point(logic signed [31:0] p[3], logic pv, logic fe,
                                     logic [47:0] now);
    bit in_box;
    bit miss;
    logic signed [31:0] cen[3];
    frame_result_t res;
    in_box = 1'b1;
    if (!in_frame) begin
      open_frame(now);
      for (int a = 0; a < 3; a++) sums[a] = 0;
      kept = 0;
    end
    for (int a = 0; a < 3; a++)
      if (p[a] < gate[2*a] || p[a] > gate[2*a+1]) in_box = 1'b0;
    if (pv && in_box && kept < MaxKept) begin
      for (int a = 0; a < 3; a++) sums[a] += longint'(p[a]);
      kept++;
    end
    if (!fe) begin
      in_frame = 1'b1;
      return;
    end
    in_frame = 1'b0;
    for (int a = 0; a < 3; a++) cen[a] = centroid_of(sums[a], kept);
    if (locating) begin
      miss = !(kept > min_pts);
      if (!miss) begin
        locating = 1'b0;
        track_phase = 1;
      end else begin
        track_phase = 0;
      end
    end else begin
      miss = kept < min_pts;
      if (miss) begin
        // lost object: history stays as it is
        locating = 1'b1;
        track_phase = 0;
        res = '{cx: '0, cy: '0, cz: '0, lost: 1'b1};
        result_q.push_back(res);
        return;
      end
    end
    prev_time = last_time;
    last_time = now;
    for (int a = 0; a < 3; a++) begin
      prev_pos[a] = last_pos[a];
      last_pos[a] = cen[a];
    end
    res.cx = miss ? '0 : cen[0];
    res.cy = miss ? '0 : cen[1];
    res.cz = miss ? '0 : cen[2];
    res.lost = miss;
    result_q.push_back(res);
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch at %0t: result %0d field %s got %0d expected %0d",
             $realtime, results_o, field, got, want);
    fail_count_o++;
  endtask

  // predictor state and comparison, all at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] pt[3];
    frame_result_t want;
    if (!rst_ni) begin
      for (int a = 0; a < 6; a++) begin
        frame_bound[a] = (a % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
        gate[a] = '0;
      end
      half_width = 31'd6554;
      min_pts = 20'd5;
      locating = 1'b1;
      track_phase = 0;
      for (int a = 0; a < 3; a++) begin
        last_pos[a] = '0;
        prev_pos[a] = '0;
        sums[a] = 0;
      end
      last_time = '0;
      prev_time = '0;
      kept = 0;
      in_frame = 1'b0;
    end else begin
      // result transaction
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (centroid_x_i !== want.cx) report("centroid_x", centroid_x_i, want.cx);
          if (centroid_y_i !== want.cy) report("centroid_y", centroid_y_i, want.cy);
          if (centroid_z_i !== want.cz) report("centroid_z", centroid_z_i, want.cz);
          if (not_found_i !== want.lost) report("not_found", not_found_i, want.lost);
          if (!want.lost) found_o++;
        end
        results_o++;
      end
      // config transaction
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i) inside
          bgct_pkg::RegFrameXLo, bgct_pkg::RegFrameXHi, bgct_pkg::RegFrameYLo,
          bgct_pkg::RegFrameYHi, bgct_pkg::RegFrameZLo,
          bgct_pkg::RegFrameZHi: frame_bound[cfg_index_i] = cfg_data_i;
          bgct_pkg::RegHalfW:  half_width = cfg_data_i[30:0];
          bgct_pkg::RegMinPts: min_pts = cfg_data_i[19:0];
          default: ;
        endcase
      end
      // point transaction
      if (in_valid_i && in_ready_i) begin
        pt[0] = point_x_i;
        pt[1] = point_y_i;
        pt[2] = point_z_i;
        take_point(pt, point_valid_i, frame_end_i, frame_time_i);
      end
    end
  end

  initial begin
    fail_count_o = 0;
    results_o = 0;
    found_o = 0;
  end

endmodule

### dv/box_gated_centroid_tracker_test.sv
// testbench top for the box gated centroid tracker: clock, reset, stimulus and verdict
// depends on bgct_pkg, box_gated_centroid_tracker and box_gated_centroid_tracker_checker
module box_gated_centroid_tracker_test;

  localparam int StallLimit = 20000;
  localparam int DrainCycles = 600;
  localparam int PhaseItems = 165;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] point_z_i = '0;
  logic               point_valid_i = 1'b0;
  logic               frame_end_i = 1'b0;
  logic [47:0]        frame_time_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] centroid_x_o;
  logic signed [31:0] centroid_y_o;
  logic signed [31:0] centroid_z_o;
  logic               not_found_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  int fail_count;
  int pending;
  int results;
  int found;
  int points_sent = 0;
  int frames_sent = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  // object motion: position = base + rate * elapsed / 1000
  longint obj_base[3];
  longint obj_rate[3];
  logic [47:0] obj_t0;
  logic [47:0] clock_us;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  box_gated_centroid_tracker u_top (.*);

  box_gated_centroid_tracker_checker u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .point_x_i, .point_y_i, .point_z_i, .point_valid_i, .frame_end_i, .frame_time_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .centroid_x_i(centroid_x_o), .centroid_y_i(centroid_y_o), .centroid_z_i(centroid_z_o),
    .not_found_i(not_found_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results), .found_o(found)
  );

  // watchdog on cycles with no transaction at all
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no transaction for %0d cycles", StallLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result receiver: random stall bursts, one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (1500) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
                            logic pv, logic fe, logic [47:0] t);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    point_valid_i <= pv;
    frame_end_i <= fe;
    frame_time_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    points_sent++;
    if (fe) frames_sent++;
  endtask

  // wait for all results, then for the block to finish any pending work
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_config(logic [31:0] bound[6], logic [31:0] hw, logic [31:0] mp);
    drain();
    write_reg(bgct_pkg::RegFrameXLo, bound[0]);
    write_reg(bgct_pkg::RegFrameXHi, bound[1]);
    write_reg(bgct_pkg::RegFrameYLo, bound[2]);
    write_reg(bgct_pkg::RegFrameYHi, bound[3]);
    write_reg(bgct_pkg::RegFrameZLo, bound[4]);
    write_reg(bgct_pkg::RegFrameZHi, bound[5]);
    write_reg(bgct_pkg::RegHalfW, hw);
    write_reg(bgct_pkg::RegMinPts, mp);
  endtask

  function automatic logic signed [31:0] obj_at(int a, logic [47:0] t);
    logic [47:0] elapsed;
    elapsed = t - obj_t0;
    return 32'(obj_base[a] + obj_rate[a] * longint'(elapsed) / 1000);
  endfunction

  task automatic new_object(logic [47:0] t);
    for (int a = 0; a < 3; a++) begin
      obj_base[a] = longint'($urandom_range(0, 400000)) - 200000;
      obj_rate[a] = longint'($urandom_range(0, 3000)) - 1500;
    end
    obj_t0 = t;
  endtask

  // random frames: mostly points on the object, some noise and missing depth
  task automatic run_frames(int items, int jitter);
    int stop_at;
    int k;
    int pick;
    bit lost_frame;
    logic signed [31:0] c[3];
    logic signed [31:0] p[3];
    stop_at = points_sent + items;
    while (points_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) clock_us = clock_us;
      else if (pick < 8) clock_us = clock_us + 48'($urandom);
      else clock_us = clock_us + 48'($urandom_range(200, 3000));
      if ($urandom_range(0, 29) == 0) new_object(clock_us);
      lost_frame = ($urandom_range(0, 14) == 0);
      k = $urandom_range(1, 10);
      for (int a = 0; a < 3; a++) c[a] = obj_at(a, clock_us);
      for (int i = 0; i < k; i++) begin
        pick = $urandom_range(0, 99);
        for (int a = 0; a < 3; a++) begin
          if (lost_frame || pick >= 85) p[a] = $urandom;
          else p[a] = c[a] + $signed($urandom_range(0, 2 * jitter)) - jitter;
        end
        send_point(p[0], p[1], p[2], !(pick >= 93 && pick < 99), i == k - 1, clock_us);
      end
    end
  endtask

  initial begin
    logic [31:0] bound[6];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: coordinate extremes, missing depth, top time, empty frame
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b0, '0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1, 1'b0, '0);
    send_point(32'sh5555_aaaa, 32'shaaaa_5555, '0, 1'b0, 1'b0, '0);
    send_point(1, -1, 1, 1'b1, 1'b1, 48'hffff_ffff_ffff);
    send_point(5, 5, 5, 1'b0, 1'b1, 48'd100);
    // found in locate mode, then tracked, then lost
    for (int i = 0; i < 7; i++)
      send_point(65536 + i, -65536 - i, 131072, 1'b1, i == 6, 48'd1000);
    for (int i = 0; i < 7; i++)
      send_point(i == 6 ? 32'sh7fff_ffff : 65600 + i, -65500, 131000, 1'b1, i == 6, 48'd2000);
    send_point(32'sh4000_0000, 0, 0, 1'b1, 1'b1, 48'd3000);

    clock_us = 48'd5000;
    new_object(clock_us);

    // full frame box, default gate size
    bound = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff};
    load_config(bound, 32'd6554, 32'd5);
    run_frames(PhaseItems / 2, 2000);
    // receiver holds off while points keep coming
    hold_request = 1'b1;
    run_frames(PhaseItems / 2, 2000);

    // tight box around the object, zero gate, threshold zero
    for (int a = 0; a < 3; a++) begin
      bound[2*a] = 32'(obj_base[a] - 200000);
      bound[2*a+1] = 32'(obj_base[a] + 200000);
    end
    load_config(bound, 32'd0, 32'd0);
    run_frames(PhaseItems, 0);

    // widest gate with saturating bounds, time near the wrap
    bound = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff};
    load_config(bound, 32'h7fff_ffff, 32'd1);
    clock_us = 48'hffff_fff0_0000;
    new_object(clock_us);
    run_frames(PhaseItems, 3000);

    // crossed bounds and highest threshold: never found
    bound = '{32'd1000, 32'hffff_fc18, 32'h8000_0000, 32'h7fff_ffff,
              32'd0, 32'd0};
    load_config(bound, 32'hffff_ffff, 32'd524288);
    run_frames(PhaseItems / 2, 3000);

    // box around the object, wider gate
    for (int a = 0; a < 3; a++) begin
      bound[2*a] = 32'(obj_base[a] - 200000);
      bound[2*a+1] = 32'(obj_base[a] + 200000);
    end
    load_config(bound, 32'd20000, 32'd3);
    run_frames(PhaseItems, 6000);

    // last part without idling on either side
    load_config(bound, 32'd12000, 32'd2);
    calm = 1'b1;
    run_frames(PhaseItems, 4000);

    drain();
    $display("run covered %0d points in %0d frames, %0d results (%0d with object found)",
             points_sent, frames_sent, results, found);
    $display("configs: full, tight, crossed and saturating boxes; thresholds 0 to 524288");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
